// ===== rtl/core/asnr_pkg.sv =====
package asnr_pkg;

	// Field widths of the two channels.
	localparam int unsigned VALUE_W  = 64;
	localparam int unsigned OCTET_W  = 8;
	localparam int unsigned LENGTH_W = 4;

	// Longest encoding buffer: header, two exponent octets, seven mantissa octets.
	localparam int unsigned MAX_OCTETS = 10;
	localparam int unsigned BUF_W      = MAX_OCTETS * OCTET_W;

	// IEEE-754 double layout.
	localparam logic [10:0] BEXP_SPECIAL = 11'h7ff;
	localparam logic [12:0] EXP_OFFSET   = 13'd1027;

	// Fixed content octets.
	localparam logic [7:0] HDR_BINARY = 8'h80;
	localparam logic [7:0] OCT_PLUS_INF  = 8'h40;
	localparam logic [7:0] OCT_MINUS_INF = 8'h41;

	typedef logic [VALUE_W-1:0]  value_t;
	typedef logic [OCTET_W-1:0]  octet_t;
	typedef logic [LENGTH_W-1:0] length_t;
	typedef logic [BUF_W-1:0]    octet_buf_t;

endpackage

// ===== rtl/core/asnr_in_if.sv =====
interface asnr_in_if;
	import asnr_pkg::*;

	logic   valid;
	logic   ready;
	value_t value_bits;

	modport source (output valid, output value_bits, input ready);
	modport sink   (input valid, input value_bits, output ready);
endinterface

// ===== rtl/core/asnr_out_if.sv =====
interface asnr_out_if;
	import asnr_pkg::*;

	logic    valid;
	logic    ready;
	octet_t  octet;
	logic    last;
	length_t content_length;

	modport source (output valid, output octet, output last, output content_length, input ready);
	modport sink   (input valid, input octet, input last, input content_length, output ready);
endinterface

// ===== rtl/core/double_to_asn1_real_encoder.sv =====
// Encoder of IEEE-754 doubles into the content octets of an ASN.1 binary REAL.
//
// The value channel takes one request per double as 64 raw bits. The encoding
// channel returns its content octets one per request, first octet first, with
// last marking the final octet and content_length giving the total for the
// value. Zero and subnormals give a single request with length zero and octet
// zero; infinities and NaN give one octet.
//
// A double is captured in an input register and fully encoded by one pass of
// logic into a ten-octet buffer, from which its first octet is offered. The
// buffer then shifts out one octet per cycle while the receiver takes them;
// a value takes one to ten requests (header, one or two exponent octets, one
// to seven mantissa octets), and the octet channel sets the sustained rate.
// The input register accepts the next double while the buffer is still
// draining, so a waiting double is loaded into the buffer as the last octet
// of the previous value is taken.
//
// When the receiver stalls the buffer holds its octet, the input register
// holds one further double, and then the value channel stalls. Reset clears
// both valid flags and the octet counter; the data registers are not reset.
module double_to_asn1_real_encoder (
	input logic        clk,
	input logic        arst_n,
	asnr_in_if.sink    value,
	asnr_out_if.source encoding
);
	import asnr_pkg::*;

	// Stage 1: input register.
	logic   s1_valid_q;
	value_t bits_s1;

	// Stage 2: encoded octet buffer being shifted out.
	logic       s2_valid_q;
	octet_buf_t buf_s2;
	length_t    len_s2;
	length_t    rem_s2;

	logic s2_take;
	logic s2_done;
	logic s1_move;

	assign s2_take = s2_valid_q && encoding.ready;
	assign s2_done = s2_take && (rem_s2 == length_t'(1));
	assign s1_move = s1_valid_q && (!s2_valid_q || s2_done);
	assign value.ready = !s1_valid_q || s1_move;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (value.ready) begin
			s1_valid_q <= value.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (value.valid && value.ready) begin
			bits_s1 <= value.value_bits;
		end
	end

	// Field split of the captured double.
	logic        sgn;
	logic [10:0] bexp;
	logic [55:0] mant;

	assign sgn  = bits_s1[63];
	assign bexp = bits_s1[62:52];
	assign mant = {3'b000, 1'b1, bits_s1[51:0]};

	// Index of the last nonzero mantissa octet; octet 0 always holds the implicit one.
	logic [2:0] mstop;
	always_comb begin
		mstop = 3'd0;
		for (int i = 1; i <= 6; i++) begin
			if (mant[8*(6-i) +: 8] != 8'h00) begin
				mstop = 3'(i);
			end
		end
	end

	// Drop the trailing zero octets.
	logic [55:0] n_oct;
	always_comb begin
		unique case (mstop)
			3'd0:    n_oct = mant >> 48;
			3'd1:    n_oct = mant >> 40;
			3'd2:    n_oct = mant >> 32;
			3'd3:    n_oct = mant >> 24;
			3'd4:    n_oct = mant >> 16;
			3'd5:    n_oct = mant >> 8;
			default: n_oct = mant;
		endcase
	end

	// Trailing zero bits of the lowest kept octet, which is never zero.
	logic [2:0] tz;
	always_comb begin
		tz = 3'd7;
		for (int b = 6; b >= 0; b--) begin
			if (n_oct[b]) begin
				tz = 3'(b);
			end
		end
	end

	logic [55:0] n_odd;
	assign n_odd = n_oct >> tz;

	// Left-justify the kept mantissa octets for shifting out.
	logic [55:0] mant_lj;
	always_comb begin
		unique case (mstop)
			3'd0:    mant_lj = n_odd << 48;
			3'd1:    mant_lj = n_odd << 40;
			3'd2:    mant_lj = n_odd << 32;
			3'd3:    mant_lj = n_odd << 24;
			3'd4:    mant_lj = n_odd << 16;
			3'd5:    mant_lj = n_odd << 8;
			default: mant_lj = n_odd;
		endcase
	end

	// Unbiased exponent of the odd integer mantissa; it lies within -1074..1023.
	logic [12:0] expo;
	logic [15:0] expo16;
	logic        elen_one;

	assign expo     = {2'b00, bexp} - EXP_OFFSET - {7'd0, mstop, 3'b000} + {10'd0, tz};
	assign expo16   = {{3{expo[12]}}, expo};
	assign elen_one = (expo[12:7] == 6'b000000) || (expo[12:7] == 6'b111111);

	// Assemble the whole encoding.
	octet_buf_t enc_buf;
	length_t    enc_len;
	length_t    enc_rem;
	octet_t     header;

	assign header = HDR_BINARY | {1'b0, sgn, 5'd0, !elen_one};

	always_comb begin
		if (bexp == 11'd0) begin
			enc_buf = '0;
			enc_len = length_t'(0);
			enc_rem = length_t'(1);
		end else if (bexp == BEXP_SPECIAL) begin
			enc_buf = {((bits_s1[51:0] == 52'd0) && !sgn) ? OCT_PLUS_INF : OCT_MINUS_INF,
				{(BUF_W-OCTET_W){1'b0}}};
			enc_len = length_t'(1);
			enc_rem = length_t'(1);
		end else if (elen_one) begin
			enc_buf = {header, expo16[7:0], mant_lj, 8'h00};
			enc_len = length_t'(3) + length_t'(mstop);
			enc_rem = enc_len;
		end else begin
			enc_buf = {header, expo16[15:8], expo16[7:0], mant_lj};
			enc_len = length_t'(4) + length_t'(mstop);
			enc_rem = enc_len;
		end
	end

	// Output buffer and octet counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			rem_s2     <= '0;
		end else if (s1_move) begin
			s2_valid_q <= 1'b1;
			rem_s2     <= enc_rem;
		end else if (s2_done) begin
			s2_valid_q <= 1'b0;
		end else if (s2_take) begin
			rem_s2 <= rem_s2 - length_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			buf_s2 <= enc_buf;
			len_s2 <= enc_len;
		end else if (s2_take) begin
			buf_s2 <= buf_s2 << OCTET_W;
		end
	end

	assign encoding.valid          = s2_valid_q;
	assign encoding.octet          = buf_s2[BUF_W-1 -: OCTET_W];
	assign encoding.last           = (rem_s2 == length_t'(1));
	assign encoding.content_length = len_s2;

	// A live buffer always has an octet left and never more than the value's length, except a zero value of length zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q |-> (rem_s2 != length_t'(0)) &&
			((rem_s2 <= len_s2) || (len_s2 == length_t'(0))))
		else $error("octet counter out of range");

	// A zero value shows a zero octet and length zero on a single request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid_q && (len_s2 == length_t'(0))) |->
			(encoding.last && (encoding.octet == 8'h00)))
		else $error("zero value not encoded as a single empty request");

	// A finished value with nothing waiting behind it empties the buffer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s2_done && !s1_valid_q) |=> !s2_valid_q)
		else $error("buffer not released after last octet");

	// A stalled value with a full input register blocks new doubles.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && s2_valid_q && !encoding.ready) |-> !value.ready)
		else $error("input accepted while both stages are held");

	// An accepted double passes through the input register into the buffer when both stages are free.
	assert property (@(posedge clk) disable iff (!arst_n)
		(value.valid && value.ready && !s1_valid_q && !s2_valid_q) |=> ##1 s2_valid_q)
		else $error("encoding not presented after acceptance");

endmodule
